FILE: hdl/knnv_pkg.sv
`default_nettype none

package knnv_pkg;

  localparam int K_MAX_DEF        = 16;
  localparam int FEATURE_BITS_DEF = 16;
  localparam int K_W              = 5;
  localparam int VOTE_W           = 5;
  localparam logic [K_W-1:0] K_RESET = 5'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DEC,
    S_UP_RQ,
    S_UP_CMP,
    S_DN_RQ,
    S_DN_CMP,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              approved;
    logic [VOTE_W-1:0] approved_votes;
    logic [VOTE_W-1:0] failed_votes;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/knnv_dist.sv
`default_nettype none

module knnv_dist #(
  parameter int FEATURE_BITS = knnv_pkg::FEATURE_BITS_DEF,
  parameter int DW           = 2 * FEATURE_BITS + 2
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [FEATURE_BITS-1:0] query_grade,
  input  wire logic [FEATURE_BITS-1:0] query_hours,
  input  wire logic [FEATURE_BITS-1:0] sample_grade,
  input  wire logic [FEATURE_BITS-1:0] sample_hours,
  output logic      [DW-1:0]           sq_dist
);

  localparam int SW = 2 * FEATURE_BITS;

  logic [FEATURE_BITS-1:0] dg;
  logic [FEATURE_BITS-1:0] dh;
  logic [SW-1:0]           dg_w;
  logic [SW-1:0]           dh_w;
  logic [SW-1:0]           sq_g;
  logic [SW-1:0]           sq_h;

  always_comb begin
    dg   = (query_grade > sample_grade) ? query_grade - sample_grade
                                        : sample_grade - query_grade;
    dh   = (query_hours > sample_hours) ? query_hours - sample_hours
                                        : sample_hours - query_hours;
    dg_w = SW'(dg);
    dh_w = SW'(dh);
  end

  // squares taken on the accepting edge, summed on the next
  always_ff @(posedge clk) begin
    if (en) begin
      sq_g <= dg_w * dg_w;
      sq_h <= dh_w * dh_w;
    end
    sq_dist <= DW'(sq_g) + DW'(sq_h);
  end

endmodule

`default_nettype wire

FILE: hdl/knnv_heap_ram.sv
`default_nettype none

module knnv_heap_ram #(
  parameter int DEPTH = knnv_pkg::K_MAX_DEF,
  parameter int AW    = 4,
  parameter int EW    = 35
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] ra,
  input  wire logic [AW-1:0] rb,
  output logic      [EW-1:0] rd_a,
  output logic      [EW-1:0] rd_b,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [EW-1:0] wd
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

endmodule

`default_nettype wire

FILE: hdl/knnv_heap_ctrl.sv
`default_nettype none

module knnv_heap_ctrl #(
  parameter int DW    = 34,
  parameter int CW    = 5,
  parameter int AW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 sample_label,
  input  wire logic                 last_sample,
  input  wire logic [CW-1:0]        k_eff,
  input  wire logic                 cfg_we,
  input  wire logic [CW-1:0]        cfg_k_eff,
  input  wire logic [DW-1:0]        sq_dist,
  output logic      [AW-1:0]        ra,
  output logic      [AW-1:0]        rb,
  input  wire logic [DW:0]          rd_a,
  input  wire logic [DW:0]          rd_b,
  output logic                      we,
  output logic      [AW-1:0]        wa,
  output logic      [DW:0]          wd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output knnv_pkg::result_t         res
);

  localparam int LW = AW + 1;

  knnv_pkg::state_t state, state_next, done_state;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] node, node_next;
  logic [DW:0]   carried, carried_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic          scan_valid, scan_valid_next;
  logic [CW-1:0] yes, yes_next;
  logic [CW-1:0] no, no_next;
  logic          label_q;
  logic          last_q;

  logic [DW:0]   new_entry;
  logic [AW-1:0] lim;
  logic [LW-1:0] lim_ext;
  logic [LW-1:0] left;
  logic [LW-1:0] right;
  logic [AW-1:0] parent;
  logic [AW-1:0] big;
  logic [DW:0]   big_val;
  logic          in_accept;

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= knnv_pkg::S_IDLE;
      count      <= '0;
      scan_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      scan_valid <= scan_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    node     <= node_next;
    carried  <= carried_next;
    scan_idx <= scan_idx_next;
    yes      <= yes_next;
    no       <= no_next;
    if (in_accept) begin
      label_q <= sample_label;
      last_q  <= last_sample;
    end
  end

  always_comb begin
    new_entry  = {label_q, sq_dist};
    lim        = AW'(k_eff - CW'(1));
    lim_ext    = LW'(lim);
    left       = LW'(node) * LW'(2) + LW'(1);
    right      = left + LW'(1);
    parent     = (pos - AW'(1)) >> 1;
    done_state = last_q ? knnv_pkg::S_SCAN : knnv_pkg::S_IDLE;

    // larger child, left checked first, right only if strictly larger still
    big     = node;
    big_val = carried;
    if (rd_a[DW-1:0] > carried[DW-1:0]) begin
      big     = left[AW-1:0];
      big_val = rd_a;
    end
    if (right < lim_ext && rd_b[DW-1:0] > big_val[DW-1:0]) begin
      big     = right[AW-1:0];
      big_val = rd_b;
    end

    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    node_next       = node;
    carried_next    = carried;
    scan_idx_next   = scan_idx;
    scan_valid_next = scan_valid;
    yes_next        = yes;
    no_next         = no;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    ra              = '0;
    rb              = '0;
    we              = 1'b0;
    wa              = pos;
    wd              = carried;

    // lowering k drops the tail of the heap
    if (cfg_we && count > cfg_k_eff) begin
      count_next = cfg_k_eff;
    end

    unique case (state)
      knnv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next      = knnv_pkg::S_SUM;
          scan_idx_next   = '0;
          scan_valid_next = 1'b0;
          yes_next        = '0;
          no_next         = '0;
        end
      end
      knnv_pkg::S_SUM: begin
        ra         = '0;
        rb         = lim;
        state_next = knnv_pkg::S_DEC;
      end
      knnv_pkg::S_DEC: begin
        if (count < k_eff) begin
          pos_next     = AW'(count);
          count_next   = count + CW'(1);
          carried_next = new_entry;
          state_next   = knnv_pkg::S_UP_RQ;
        end else if (sq_dist < rd_a[DW-1:0]) begin
          // root leaves: last entry is carried down from the root
          carried_next = rd_b;
          node_next    = '0;
          state_next   = knnv_pkg::S_DN_RQ;
        end else begin
          state_next = done_state;
        end
      end
      knnv_pkg::S_UP_RQ: begin
        ra = parent;
        if (pos == '0) begin
          we         = 1'b1;
          wa         = pos;
          wd         = carried;
          state_next = done_state;
        end else begin
          state_next = knnv_pkg::S_UP_CMP;
        end
      end
      knnv_pkg::S_UP_CMP: begin
        we = 1'b1;
        wa = pos;
        if (rd_a[DW-1:0] < carried[DW-1:0]) begin
          wd         = rd_a;
          pos_next   = parent;
          state_next = knnv_pkg::S_UP_RQ;
        end else begin
          wd         = carried;
          state_next = done_state;
        end
      end
      knnv_pkg::S_DN_RQ: begin
        ra = left[AW-1:0];
        rb = right[AW-1:0];
        if (left >= lim_ext) begin
          we           = 1'b1;
          wa           = node;
          wd           = carried;
          pos_next     = lim;
          carried_next = new_entry;
          state_next   = knnv_pkg::S_UP_RQ;
        end else begin
          state_next = knnv_pkg::S_DN_CMP;
        end
      end
      knnv_pkg::S_DN_CMP: begin
        we = 1'b1;
        wa = node;
        if (big == node) begin
          wd           = carried;
          pos_next     = lim;
          carried_next = new_entry;
          state_next   = knnv_pkg::S_UP_RQ;
        end else begin
          wd         = big_val;
          node_next  = big;
          state_next = knnv_pkg::S_DN_RQ;
        end
      end
      knnv_pkg::S_SCAN: begin
        if (scan_valid) begin
          if (rd_a[DW]) begin
            yes_next = yes + CW'(1);
          end else begin
            no_next = no + CW'(1);
          end
        end
        if (scan_idx < count) begin
          ra              = AW'(scan_idx);
          scan_idx_next   = scan_idx + CW'(1);
          scan_valid_next = 1'b1;
        end else begin
          scan_valid_next = 1'b0;
          if (!scan_valid) begin
            state_next = knnv_pkg::S_OUT;
          end
        end
      end
      knnv_pkg::S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          count_next = '0;
          state_next = knnv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = knnv_pkg::S_IDLE;
      end
    endcase

    res.approved       = yes > no;
    res.approved_votes = knnv_pkg::VOTE_W'(yes);
    res.failed_votes   = knnv_pkg::VOTE_W'(no);
  end

endmodule

`default_nettype wire

FILE: hdl/knn_vote_classifier.sv
`default_nettype none
// one sample transaction at a time: a sample is dropped, fills a free heap slot
// and sifts up, or evicts the root, sifts the last entry down from the root and
// then sifts the new entry up
// the last sample also reads out the labels before the result
// a result waits in an output register while the next sample is taken
// rst is synchronous: heap emptied, k back to 3, heap memory not cleared

module knn_vote_classifier #(
  parameter int K_MAX        = knnv_pkg::K_MAX_DEF,
  parameter int FEATURE_BITS = knnv_pkg::FEATURE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [knnv_pkg::K_W-1:0]     k_neighbors,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [FEATURE_BITS-1:0]      query_grade,
  input  wire logic [FEATURE_BITS-1:0]      query_hours,
  input  wire logic [FEATURE_BITS-1:0]      sample_grade,
  input  wire logic [FEATURE_BITS-1:0]      sample_hours,
  input  wire logic                         sample_label,
  input  wire logic                         last_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              approved,
  output logic      [knnv_pkg::VOTE_W-1:0]  approved_votes,
  output logic      [knnv_pkg::VOTE_W-1:0]  failed_votes
);

  localparam int DW  = 2 * FEATURE_BITS + 2;
  localparam int CW  = $clog2(K_MAX + 1);
  localparam int AW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int XW  = (CW > knnv_pkg::K_W) ? CW : knnv_pkg::K_W;

  function automatic logic [CW-1:0] eff_k(input logic [knnv_pkg::K_W-1:0] k);
    logic [XW-1:0] kx;
    kx = XW'(k);
    if (kx == '0) begin
      eff_k = CW'(1);
    end else if (kx > XW'(K_MAX)) begin
      eff_k = CW'(K_MAX);
    end else begin
      eff_k = CW'(kx);
    end
  endfunction

  logic [knnv_pkg::K_W-1:0] k_reg;
  logic [CW-1:0]            k_eff;
  logic [CW-1:0]            cfg_k_eff;
  logic [DW-1:0]            sq_dist;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            rb;
  logic [DW:0]              rd_a;
  logic [DW:0]              rd_b;
  logic                     we;
  logic [AW-1:0]            wa;
  logic [DW:0]              wd;
  logic                     res_valid;
  logic                     res_ready;
  knnv_pkg::result_t        res;
  knnv_pkg::result_t        out_res;

  assign k_eff     = eff_k(k_reg);
  assign cfg_k_eff = eff_k(k_neighbors);
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg     <= knnv_pkg::K_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_reg <= k_neighbors;
      end
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign approved       = out_res.approved;
  assign approved_votes = out_res.approved_votes;
  assign failed_votes   = out_res.failed_votes;

  knnv_dist #(
    .FEATURE_BITS (FEATURE_BITS),
    .DW           (DW)
  ) u_dist (
    .clk          (clk),
    .en           (in_valid && in_ready),
    .query_grade  (query_grade),
    .query_hours  (query_hours),
    .sample_grade (sample_grade),
    .sample_hours (sample_hours),
    .sq_dist      (sq_dist)
  );

  knnv_heap_ram #(
    .DEPTH (K_MAX),
    .AW    (AW),
    .EW    (DW + 1)
  ) u_ram (
    .clk  (clk),
    .ra   (ra),
    .rb   (rb),
    .rd_a (rd_a),
    .rd_b (rd_b),
    .we   (we),
    .wa   (wa),
    .wd   (wd)
  );

  knnv_heap_ctrl #(
    .DW    (DW),
    .CW    (CW),
    .AW    (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_label (sample_label),
    .last_sample  (last_sample),
    .k_eff        (k_eff),
    .cfg_we       (cfg_we),
    .cfg_k_eff    (cfg_k_eff),
    .sq_dist      (sq_dist),
    .ra           (ra),
    .rb           (rb),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .we           (we),
    .wa           (wa),
    .wd           (wd),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

endmodule

`default_nettype wire

FILE: hdl/knnv_checker.sv
`default_nettype none

module knnv_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        approved,
  input wire logic [knnv_pkg::VOTE_W-1:0] approved_votes,
  input wire logic [knnv_pkg::VOTE_W-1:0] failed_votes
);

  logic [knnv_pkg::VOTE_W:0] vote_sum;

  assign vote_sum = (knnv_pkg::VOTE_W + 1)'(approved_votes)
                  + (knnv_pkg::VOTE_W + 1)'(failed_votes);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable({approved, approved_votes, failed_votes}))
    else $error("result changed while stalled");

  // the verdict follows the two counts, a tie is a refusal
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> approved == (approved_votes > failed_votes))
    else $error("verdict does not match vote counts");

  // at least one neighbour and never more than the heap holds
  a_vote_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vote_sum != '0
      && vote_sum <= (knnv_pkg::VOTE_W + 1)'(knnv_pkg::K_MAX_DEF))
    else $error("vote count out of range");

  // each transaction keeps the heap busy, so samples are never taken back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while heap busy");

endmodule

bind knn_vote_classifier knnv_checker u_knnv_checker (.*);

`default_nettype wire
